### hdl/tfse_pkg.sv
// Shared constants and types for the telemetry frame stuffing encoder.
`default_nettype none

package tfse_pkg;

   // frame layout
   localparam int PayloadBytes = 6;                 // two id bytes, four value bytes
   localparam int NumSlots     = PayloadBytes + 1;  // payload plus checksum
   localparam int SumWidth     = 11;                // 0x10 + 6 * 0xFF fits in 11 bits
   localparam int SlotIdxWidth = $clog2(NumSlots + 1);

   // byte codes
   localparam logic [7:0] FrameType = 8'h10;
   localparam logic [7:0] FlagByte  = 8'h7E;
   localparam logic [7:0] EscByte   = 8'h7D;
   localparam logic [7:0] EscMask   = 8'h20;  // 7E -> 5E, 7D -> 5D
   localparam logic [7:0] CheckBase = 8'hFF;

   typedef logic [PayloadBytes-1:0][7:0] tfse_payload_type;

   // one byte of the frame and whether it goes out escaped
   typedef struct packed {
      logic [7:0] data;
      logic       esc;
   } tfse_slot_type;

   typedef tfse_slot_type [NumSlots-1:0] tfse_frame_type;

endpackage

`default_nettype wire

### hdl/tfse_sum.sv
// Input register stage and raw checksum accumulation stage.
`default_nettype none

module tfse_sum
   import tfse_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_stall,
   input  wire logic [15:0]         in_sensor_id,
   input  wire logic [31:0]         in_value,
   output      logic                out_valid,
   input  wire logic                out_take,
   output      tfse_payload_type    out_payload,
   output      logic [SumWidth-1:0] out_total
);

   logic                s1_valid_ff, s1_valid_in;
   logic [15:0]         s1_id_ff;
   logic [31:0]         s1_value_ff;
   logic                s2_valid_ff, s2_valid_in;
   tfse_payload_type    s2_payload_ff, s2_payload_in;
   logic [SumWidth-1:0] s2_total_ff, s2_total_in;
   logic                s1_take, s2_take;

   // stage advance: a stage takes a beat when empty or when it moves on
   always_comb begin
      s2_take  = !s2_valid_ff || out_take;
      s1_take  = !s1_valid_ff || s2_take;
      in_stall = !s1_take;
   end

   // plain sum of frame type and payload bytes, carry folded later
   always_comb begin
      s1_valid_in   = s1_take ? in_valid : s1_valid_ff;
      s2_valid_in   = s2_take ? s1_valid_ff : s2_valid_ff;
      s2_payload_in = {s1_value_ff, s1_id_ff};
      s2_total_in   = SumWidth'(FrameType);
      for (int i = 0; i < PayloadBytes; i++) begin
         s2_total_in = s2_total_in + SumWidth'(s2_payload_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_take) begin
         s1_id_ff    <= in_sensor_id;
         s1_value_ff <= in_value;
      end
      if (s2_take) begin
         s2_payload_ff <= s2_payload_in;
         s2_total_ff   <= s2_total_in;
      end
   end

   assign out_valid   = s2_valid_ff;
   assign out_payload = s2_payload_ff;
   assign out_total   = s2_total_ff;

endmodule

`default_nettype wire

### hdl/tfse_stuff.sv
// Checksum fold stage and escape marking of every stuffed byte.
`default_nettype none

module tfse_stuff
   import tfse_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output      logic                in_take,
   input  wire tfse_payload_type    in_payload,
   input  wire logic [SumWidth-1:0] in_total,
   output      logic                out_valid,
   input  wire logic                out_take,
   output      tfse_frame_type      out_frame
);

   logic           s3_valid_ff, s3_valid_in;
   tfse_frame_type s3_frame_ff, s3_frame_in;
   logic [8:0]     fold1;
   logic [7:0]     sum8;

   assign in_take = !s3_valid_ff || out_take;

   // end-around carry fold; the sum is never zero since it starts at 0x10
   always_comb begin
      fold1 = {1'b0, in_total[7:0]} + 9'(in_total[SumWidth-1:8]);
      sum8  = fold1[7:0] + 8'(fold1[8]);
      for (int i = 0; i < PayloadBytes; i++) begin
         s3_frame_in[i].data = in_payload[i];
      end
      s3_frame_in[NumSlots-1].data = CheckBase - sum8;
      for (int i = 0; i < NumSlots; i++) begin
         s3_frame_in[i].esc = (s3_frame_in[i].data == FlagByte) ||
                              (s3_frame_in[i].data == EscByte);
      end
      s3_valid_in = in_take ? in_valid : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      if (in_take) begin
         s3_frame_ff <= s3_frame_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_frame = s3_frame_ff;

endmodule

`default_nettype wire

### hdl/tfse_serial.sv
// Byte serializer: walks the frame slots and emits escape pairs.
`default_nettype none

module tfse_serial
   import tfse_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output      logic           in_take,
   input  wire tfse_frame_type in_frame,
   output      logic           out_valid,
   input  wire logic           out_stall,
   output      logic [7:0]     out_byte,
   output      logic           out_last
);

   localparam logic [SlotIdxWidth-1:0] LastSlot = SlotIdxWidth'(NumSlots);

   logic                          ser_valid_ff, ser_valid_in;
   tfse_slot_type [NumSlots:0]    ser_frame_ff;
   logic [SlotIdxWidth-1:0]       slot_ff, slot_in;
   logic                          half_ff, half_in;
   tfse_slot_type                 cur;
   tfse_slot_type                 head;
   logic                          fire, is_last;

   // current slot and output byte
   always_comb begin
      cur      = ser_frame_ff[slot_ff];
      is_last  = (slot_ff == LastSlot) && (half_ff || !cur.esc);
      fire     = ser_valid_ff && !out_stall;
      in_take  = !ser_valid_ff || (fire && is_last);
      out_byte = half_ff ? (cur.data ^ EscMask) : (cur.esc ? EscByte : cur.data);
      head     = '{data: FrameType, esc: 1'b0};
   end

   // walk: escape pairs take two beats, a new frame loads on the last beat or when empty
   always_comb begin
      ser_valid_in = ser_valid_ff;
      slot_in      = slot_ff;
      half_in      = half_ff;
      if (in_take) begin
         ser_valid_in = in_valid;
         slot_in      = '0;
         half_in      = 1'b0;
      end else if (fire) begin
         if (cur.esc && !half_ff) begin
            half_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
            half_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         slot_ff      <= '0;
         half_ff      <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
         slot_ff      <= slot_in;
         half_ff      <= half_in;
      end
      if (in_take) begin
         ser_frame_ff <= {in_frame, head};
      end
   end

   assign out_valid = ser_valid_ff;
   assign out_last  = is_last;

endmodule

`default_nettype wire

### hdl/telemetry_frame_stuffing_encoder.sv
// Top level of the telemetry frame stuffing encoder.
`default_nettype none

// Each accepted record (16-bit id, 32-bit value) becomes one frame: 0x10,
// the six payload bytes LSB first, then the checksum, with 0x7E and 0x7D
// escaped as 0x7D 0x5E and 0x7D 0x5D, so each escaped byte lengthens the
// frame by one byte. rsp_last marks the final byte. The output runs one
// byte per cycle while rsp_stall is low; the serializer, busy with a frame
// until its last byte goes out, sets the sustained rate. Three pipeline
// stages (input register, raw sum, checksum fold and escape marking) sit
// ahead of it, so the next records are taken while a frame is still going
// out. A record passes these stages and the serializer register in order.
module telemetry_frame_stuffing_encoder
   import tfse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [15:0] req_sensor_id,
   input  wire logic [31:0] req_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_last
);

   logic                sum_valid, sum_take;
   tfse_payload_type    sum_payload;
   logic [SumWidth-1:0] sum_total;
   logic                stuff_valid, stuff_take;
   tfse_frame_type      stuff_frame;

   tfse_sum u_sum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_sensor_id (req_sensor_id),
      .in_value     (req_value),
      .out_valid    (sum_valid),
      .out_take     (sum_take),
      .out_payload  (sum_payload),
      .out_total    (sum_total)
   );

   tfse_stuff u_stuff (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sum_valid),
      .in_take    (sum_take),
      .in_payload (sum_payload),
      .in_total   (sum_total),
      .out_valid  (stuff_valid),
      .out_take   (stuff_take),
      .out_frame  (stuff_frame)
   );

   tfse_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stuff_valid),
      .in_take   (stuff_take),
      .in_frame  (stuff_frame),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last)
   );

endmodule

`default_nettype wire

### hdl/tfse_checker.sv
// Port-level checker for the telemetry frame stuffing encoder, with bind.
`default_nettype none

module tfse_checker
   import tfse_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [15:0] req_sensor_id,
   input wire logic [31:0] req_value,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_last
);

   // stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_sensor_id) && $stable(req_value))
      else $error("req beat changed while stalled");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // a flag code never leaves unescaped
   a_no_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte != FlagByte)
      else $error("unescaped flag byte on rsp");

   // an escape byte never ends a frame
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte == EscByte |-> !rsp_last)
      else $error("frame ends on escape byte");

   // an escape is followed at once by an escaped code (0x5E or 0x5D)
   a_esc_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_out_byte == EscByte |=>
         rsp_valid && (rsp_out_byte == (FlagByte ^ EscMask) ||
                       rsp_out_byte == (EscByte ^ EscMask)))
      else $error("escape byte not followed by escaped code");

endmodule

bind telemetry_frame_stuffing_encoder tfse_checker u_tfse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_sensor_id (req_sensor_id),
   .req_value     (req_value),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last      (rsp_last)
);

`default_nettype wire

### sim/tfse_frame_checker.sv
// Checker for the telemetry frame stuffing encoder: predicts each frame and compares every beat.
module tfse_frame_checker
   import tfse_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_sensor_id,
   input  wire logic [31:0] req_value,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_last,
   output int               mismatches,
   output int               bytes_owed
);

   timeunit 1ns;
   timeprecision 1ps;

   // one byte on the line and whether it closes the frame
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } line_byte_type;

   line_byte_type frame_q[$];

   // append one byte, escaping flag and escape codes
   function automatic void push_stuffed(input logic [7:0] b, input logic is_last);
      if (b == FlagByte || b == EscByte) begin
         frame_q.push_back('{data: EscByte, last: 1'b0});
         frame_q.push_back('{data: b ^ EscMask, last: is_last});
      end else begin
         frame_q.push_back('{data: b, last: is_last});
      end
   endfunction

   // build the expected line bytes of one record
   function automatic void encode_record(input logic [15:0] id, input logic [31:0] val);
      logic [47:0] payload;
      logic [7:0]  sum;
      logic [8:0]  wide;
      logic [7:0]  b;
      payload = {val, id};
      sum = FrameType;
      frame_q.push_back('{data: FrameType, last: 1'b0});
      for (int i = 0; i < PayloadBytes; i++) begin
         b = payload[8*i +: 8];
         // end-around carry
         wide = {1'b0, sum} + {1'b0, b};
         sum = wide[7:0] + {7'd0, wide[8]};
         push_stuffed(b, 1'b0);
      end
      push_stuffed(CheckBase - sum, 1'b1);
   endfunction

   // watch both channels on every edge
   always @(posedge clock) begin
      line_byte_type want;
      int errs;
      errs = 0;
      if (reset) begin
         frame_q.delete();
         mismatches <= 0;
         bytes_owed <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_record(req_sensor_id, req_value);
         end
         if (rsp_valid && !rsp_stall) begin
            if (frame_q.size() == 0) begin
               $error("out_byte: expected nothing, got %02h (last %0b)", rsp_out_byte,
                      rsp_last);
               errs++;
            end else begin
               want = frame_q.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errs++;
               end
            end
         end
         mismatches <= mismatches + errs;
         bytes_owed <= frame_q.size();
      end
   end

endmodule

### sim/telemetry_frame_stuffing_encoder_tb.sv
// Testbench top for the telemetry frame stuffing encoder: stimulus, back-pressure and verdict.
module telemetry_frame_stuffing_encoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import tfse_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_sensor_id = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   int          mismatches;
   int          bytes_owed;

   // no-idle switches per phase
   bit send_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int stall_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   telemetry_frame_stuffing_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sensor_id (req_sensor_id),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   tfse_frame_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sensor_id (req_sensor_id),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .mismatches    (mismatches),
      .bytes_owed    (bytes_owed)
   );

   // receiver: after each beat, stall for a random length unless rsp_quiet is set
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = rsp_quiet ? 0 : $urandom_range(0, 5);
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // gap before the next record
   function automatic int draw_gap();
      return send_quiet ? 0 : int'($urandom_range(0, 5));
   endfunction

   // byte biased toward escape codes and the extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return FlagByte;
         1: return EscByte;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // offer one record and hold it until it is taken
   task automatic send_record(input logic [15:0] id, input logic [31:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sensor_id <= id;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering and let every owed byte drain
   task automatic drain_frames();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, escapes in every byte lane
      send_record(16'h0000, 32'h0000_0000);
      send_record(16'hFFFF, 32'hFFFF_FFFF);
      send_record(16'h007E, 32'h0000_0000);
      send_record(16'h7E00, 32'h0000_0000);
      send_record(16'h0000, 32'h0000_007E);
      send_record(16'h0000, 32'h0000_7E00);
      send_record(16'h0000, 32'h007E_0000);
      send_record(16'h0000, 32'h7E00_0000);
      send_record(16'h007D, 32'h0000_0000);
      send_record(16'h7D00, 32'h0000_0000);
      send_record(16'h0000, 32'h0000_007D);
      send_record(16'h0000, 32'h0000_7D00);
      send_record(16'h0000, 32'h007D_0000);
      send_record(16'h0000, 32'h7D00_0000);
      // longest frames
      send_record(16'h7E7E, 32'h7E7E_7E7E);
      send_record(16'h7D7D, 32'h7D7D_7D7D);
      // checksum lands on flag, then on escape, with and without carries
      send_record(16'h0071, 32'h0000_0000);
      send_record(16'h0072, 32'h0000_0000);
      send_record(16'hFFFF, 32'h0000_0071);
      send_record(16'hFFFF, 32'h0000_0072);
      // checksum of zero
      send_record(16'h00EF, 32'h0000_0000);
      // frame type and stuffed tails inside the payload stay plain
      send_record(16'h1010, 32'h1010_1010);
      send_record(16'h5E5D, 32'h5D5E_5D5E);
      send_record(16'hAAAA, 32'h5555_5555);
      send_record(16'h5555, 32'hAAAA_AAAA);

      // hold off until the pipeline is empty
      drain_frames();

      // random phases: both idle, none idle, sender only, receiver only
      for (int phase = 0; phase < 4; phase++) begin
         send_quiet = (phase == 1) || (phase == 3);
         rsp_quiet = (phase == 1) || (phase == 2);
         for (int k = 0; k < 34; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_record(16'($urandom), $urandom);
            end else begin
               send_record({pick_byte(), pick_byte()},
                           {pick_byte(), pick_byte(), pick_byte(), pick_byte()});
            end
         end
         if (phase == 1) begin
            drain_frames();
         end
      end

      send_quiet = 1'b0;
      rsp_quiet = 1'b0;
      drain_frames();
      repeat (40) @(posedge clock);

      if (mismatches == 0) begin
         $display("telemetry_frame_stuffing_encoder: match");
      end else begin
         $display("telemetry_frame_stuffing_encoder: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("telemetry_frame_stuffing_encoder: mismatch");
      $finish;
   end

endmodule
